// ===== sv/integer_to_ascii_dec_hex_unit_defines.svh =====
// assertion macros shared by the integer to ascii converter
`ifndef INTEGER_TO_ASCII_DEC_HEX_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_DEC_HEX_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on clk, off during reset
`define I2A_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2a assertion failed");
// next-cycle implication
`define I2A_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2a assertion failed");
`else
`define I2A_ASSERT_NOW(label, ante, cons)
`define I2A_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/i2a_pkg.sv =====
// types, constants and helpers of the integer to ascii converter
package i2a_pkg;

	localparam int unsigned VAL_W      = 32;
	localparam int unsigned DIG_W      = 4;
	localparam int unsigned MAX_DIGITS = 10;
	localparam int unsigned CNT_W      = 4;
	localparam int unsigned CHAR_W     = 7;
	localparam int unsigned QDEC_W     = 29;

	// floor(x / 10) == (x * RECIP_10) >> 35 for every 32-bit x
	localparam logic [VAL_W-1:0] RECIP_10   = 32'hCCCC_CCCD;
	localparam int unsigned      RECIP_SHIFT = 35;

	localparam logic [CHAR_W-1:0] ASC_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] ASC_A     = 7'h41;
	localparam logic [CHAR_W-1:0] ASC_MINUS = 7'h2D;
	localparam logic [DIG_W-1:0]  DEC_BASE  = 4'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIGN,
		ST_DIV,
		ST_WAIT,
		ST_EMIT
	} i2a_state_t;

	typedef struct packed {
		logic             issue;
		logic             hex;
		logic [VAL_W-1:0] mag;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] quot;
		logic [DIG_W-1:0] rem;
	} div_res_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIG_W-1:0] d);
		logic [CHAR_W-1:0] ch;
		if (d < DEC_BASE) begin
			ch = ASC_ZERO + CHAR_W'(d);
		end else begin
			ch = ASC_A + CHAR_W'(d - DEC_BASE);
		end
		return ch;
	endfunction

endpackage

// ===== sv/i2a_div_unit.sv =====
// shared divide-by-base unit: reciprocal multiply for decimal or shift for hex, registered, then quotient and remainder
module i2a_div_unit
	import i2a_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_res_t res
);

	logic [2*VAL_W-1:0]  prod;
	logic [QDEC_W-1:0]   qdec_s1;
	logic [VAL_W-1:0]    mag_s1;
	logic                hex_s1;
	logic                valid_s1;
	logic [VAL_W-1:0]    quot;
	logic [DIG_W-1:0]    ten_q_low;

	assign prod = (2*VAL_W)'(req.mag) * (2*VAL_W)'(RECIP_10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (req.issue) begin
			qdec_s1 <= prod[RECIP_SHIFT +: QDEC_W];
			mag_s1  <= req.mag;
			hex_s1  <= req.hex;
		end
	end

	always_comb begin
		if (hex_s1) begin
			quot = {4'b0000, mag_s1[VAL_W-1:DIG_W]};
		end else begin
			quot = {3'b000, qdec_s1};
		end
		// low nibble of quot*10 is enough since the remainder is below 16
		ten_q_low = {quot[0], 3'b000} + {quot[2:0], 1'b0};
		res.done  = valid_s1;
		res.quot  = quot;
		res.rem   = hex_s1 ? mag_s1[DIG_W-1:0] : (mag_s1[DIG_W-1:0] - ten_q_low);
	end

endmodule

// ===== sv/i2a_seq.sv =====
// sequencer: sign, repeated division into a digit buffer, then characters out msb first
`include "integer_to_ascii_dec_hex_unit_defines.svh"
module i2a_seq
	import i2a_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VAL_W-1:0]   value,
	input  logic               hex_mode,
	input  logic               number_present,
	output logic               busy,
	output logic [CHAR_W-1:0]  character,
	output logic               last,
	output logic               char_strobe,
	output div_req_t           div_req,
	input  div_res_t           div_res
);

	i2a_state_t          state_q, state_d;
	logic [VAL_W-1:0]    mag_q;
	logic                hex_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIG_W-1:0]    digit_q [MAX_DIGITS];
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;
	logic                strobe_q;
	logic                accept;
	logic [CNT_W-1:0]    rd_idx;

	assign accept = start && (state_q == ST_IDLE);
	assign rd_idx = cnt_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = (state_q != ST_IDLE);
		div_req.issue = (state_q == ST_DIV);
		div_req.hex   = hex_q;
		div_req.mag   = mag_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && number_present) begin
					if (value == '0) begin
						state_d = ST_EMIT;
					end else if (!hex_mode && value[VAL_W-1]) begin
						state_d = ST_SIGN;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_SIGN: state_d = ST_DIV;
			ST_DIV:  state_d = ST_WAIT;
			ST_WAIT: begin
				state_d = (div_res.quot == '0) ? ST_EMIT : ST_DIV;
			end
			ST_EMIT: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// counter and output strobe are control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_SIGN) || (state_q == ST_EMIT);
			if (accept) begin
				cnt_q <= (value == '0) ? CNT_W'(1) : '0;
			end else if (state_q == ST_WAIT) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (state_q == ST_EMIT) begin
				cnt_q <= rd_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hex_q      <= hex_mode;
			mag_q      <= (!hex_mode && value[VAL_W-1]) ? (VAL_W'(0) - value) : value;
			digit_q[0] <= '0;
		end else if (state_q == ST_WAIT) begin
			mag_q          <= div_res.quot;
			digit_q[cnt_q] <= div_res.rem;
		end
		if (state_q == ST_SIGN) begin
			char_q <= ASC_MINUS;
			last_q <= 1'b0;
		end else if (state_q == ST_EMIT) begin
			char_q <= digit_to_ascii(digit_q[rd_idx]);
			last_q <= (cnt_q == CNT_W'(1));
		end
	end

	assign character   = char_q;
	assign last        = last_q;
	assign char_strobe = strobe_q;

	`I2A_ASSERT_NEXT(a_skip_no_number, accept && !number_present, !busy && !char_strobe)
	`I2A_ASSERT_NOW(a_last_ends_item, char_strobe && last, !busy)
	`I2A_ASSERT_NOW(a_div_result_in_wait, state_q == ST_WAIT, div_res.done)
	`I2A_ASSERT_NOW(a_digit_count_bound, 1'b1, cnt_q <= CNT_W'(MAX_DIGITS))

endmodule

// ===== sv/integer_to_ascii_dec_hex_unit.sv =====
// the first character is registered out of the sign state, or the emit state for a zero, else after the divide passes
// one item at a time: start is taken only in the idle state, while busy is low
// each digit takes one pass (issue in ST_DIV, then result in ST_WAIT) through the shared divide unit
// reset clears the sequencer and the strobe; the receiver cannot stall
// results come one per cycle on character/last while char_strobe is high
module integer_to_ascii_dec_hex_unit
	import i2a_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [VAL_W-1:0]   value,
	input  logic               hex_mode,
	input  logic               number_present,
	output logic [CHAR_W-1:0]  character,
	output logic               last,
	output logic               char_strobe
);

	div_req_t div_req;
	div_res_t div_res;

	i2a_div_unit u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	i2a_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.value          (value),
		.hex_mode       (hex_mode),
		.number_present (number_present),
		.busy           (busy),
		.character      (character),
		.last           (last),
		.char_strobe    (char_strobe),
		.div_req        (div_req),
		.div_res        (div_res)
	);

endmodule
